/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hash table checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is low.
`define LPH_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define LPH_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/lph_pkg.sv */
// ----------------------------------------------------------------------------
// lph_pkg
// Shared widths, command and status codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package lph_pkg;

    localparam int KEY_W       = 31;
    localparam int IDX_W       = 7;
    localparam int POS_W       = 7;
    localparam int CFG_W       = 8;
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 3;
    localparam int WORD_W      = KEY_W + 1;   // valid mark above the key
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;
    localparam int DEF_SLOTS   = 128;
    localparam logic [CFG_W-1:0] DEF_TABLE_SIZE = 8'd128;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DROPPED   = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_DELETED   = 3'd4,
        STAT_READ      = 3'd5
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [POS_W-1:0]     position;
        logic [KEY_W-1:0]     value;
        logic                 occupied;
    } result_t;

endpackage

`default_nettype wire

/* hdl/lph_mod.sv */
// ----------------------------------------------------------------------------
// lph_mod
// Restoring remainder unit: key mod table size, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_mod
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [lph_pkg::KEY_W-1:0]     dividend,
    input  wire logic [lph_pkg::CFG_W-1:0]     divisor,
    output logic                               done,
    output logic [lph_pkg::CFG_W-1:0]          remainder
);

    localparam int CNT_W = $clog2(lph_pkg::KEY_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [lph_pkg::KEY_W-1:0]     shift_reg;
    logic [lph_pkg::CFG_W-1:0]     rem_reg;
    logic [lph_pkg::CFG_W:0]       trial;
    logic [lph_pkg::CFG_W:0]       diff;

    // Bring down the next dividend bit and subtract when it fits.
    assign trial = {rem_reg, shift_reg[lph_pkg::KEY_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            shift_reg <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= CNT_W'(lph_pkg::KEY_W);
                shift_reg <= dividend;
                rem_reg   <= '0;
            end
            else if (busy_reg)
            begin
                shift_reg <= {shift_reg[lph_pkg::KEY_W-2:0], 1'b0};
                if (trial >= {1'b0, divisor})
                    rem_reg <= diff[lph_pkg::CFG_W-1:0];
                else
                    rem_reg <= trial[lph_pkg::CFG_W-1:0];
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* hdl/lph_ram.sv */
// ----------------------------------------------------------------------------
// lph_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_ram
#(
    parameter int SLOTS = lph_pkg::DEF_SLOTS
)
(
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(SLOTS)-1:0]      wr_addr,
    input  wire logic [lph_pkg::WORD_W-1:0]    wr_data,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(SLOTS)-1:0]      rd_addr,
    output logic [lph_pkg::WORD_W-1:0]         rd_data
);

    logic [lph_pkg::WORD_W-1:0] mem [SLOTS];
    logic [lph_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/lph_ctrl.sv */
// ----------------------------------------------------------------------------
// lph_ctrl
// Sequencer: clearing pass, hashing, pipelined probe scan and slot read.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_ctrl
#(
    parameter int SLOTS = lph_pkg::DEF_SLOTS
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lph_pkg::CMD_W-1:0]     in_cmd,
    input  wire logic [lph_pkg::KEY_W-1:0]     in_key,
    input  wire logic [lph_pkg::IDX_W-1:0]     in_idx,
    input  wire logic [lph_pkg::CFG_W-1:0]     n,
    output logic                               mod_start,
    input  wire logic                          mod_done,
    input  wire logic [lph_pkg::CFG_W-1:0]     mod_rem,
    output logic                               rd_en,
    output logic [$clog2(SLOTS)-1:0]           rd_addr,
    input  wire logic [lph_pkg::WORD_W-1:0]    rd_data,
    output logic                               wr_en,
    output logic [$clog2(SLOTS)-1:0]           wr_addr,
    output logic [lph_pkg::WORD_W-1:0]         wr_data,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output lph_pkg::result_t                   res
);

    localparam int AW   = $clog2(SLOTS);
    localparam int CMAX = (1 << lph_pkg::CFG_W) - 1;
    localparam int NMAX = (SLOTS < CMAX) ? SLOTS : CMAX;
    localparam int CW   = $clog2(NMAX + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_SCAN,
        ST_READ,
        ST_READ_DATA,
        ST_DONE
    } state_t;

    state_t                        state_reg,     state_next;
    logic [AW-1:0]                 clr_addr_reg,  clr_addr_next;
    lph_pkg::cmd_t                 cmd_reg,       cmd_next;
    logic [lph_pkg::KEY_W-1:0]     key_reg,       key_next;
    logic [lph_pkg::IDX_W-1:0]     idx_reg,       idx_next;
    logic [lph_pkg::KEY_W-1:0]     moved_reg,     moved_next;
    logic [AW-1:0]                 home_reg,      home_next;
    logic [AW-1:0]                 probe_reg,     probe_next;
    logic [AW-1:0]                 chk_addr_reg,  chk_addr_next;
    logic [CW-1:0]                 issue_left_reg, issue_left_next;
    logic [CW-1:0]                 chk_left_reg,  chk_left_next;
    logic                          chk_valid_reg, chk_valid_next;
    logic                          first_reg,     first_next;
    lph_pkg::result_t              res_reg,       res_next;

    logic                          rd_occ;
    logic [lph_pkg::KEY_W-1:0]     rd_key;
    logic                          last_probe;
    logic [31:0]                   home_ext;
    logic [31:0]                   idx_ext;
    logic [31:0]                   chk_ext;
    logic [31:0]                   homepos_ext;
    logic                          idx_in_range;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a,
                                                input logic [lph_pkg::CFG_W-1:0] size);
        logic [31:0]   a_inc;
        logic [AW-1:0] r;
        a_inc = 32'(a) + 32'd1;
        if (a_inc == 32'(size))
            r = '0;
        else
            r = a_inc[AW-1:0];
        return r;
    endfunction

    assign rd_occ       = rd_data[lph_pkg::WORD_W-1];
    assign rd_key       = rd_data[lph_pkg::KEY_W-1:0];
    assign last_probe   = (chk_left_reg == CW'(1));
    assign home_ext     = 32'(mod_rem);
    assign idx_ext      = 32'(idx_reg);
    assign chk_ext      = 32'(chk_addr_reg);
    assign homepos_ext  = 32'(home_reg);
    assign idx_in_range = (idx_ext < 32'(SLOTS));

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        moved_next      = moved_reg;
        home_next       = home_reg;
        probe_next      = probe_reg;
        chk_addr_next   = chk_addr_reg;
        issue_left_next = issue_left_reg;
        chk_left_next   = chk_left_reg;
        chk_valid_next  = 1'b0;
        first_next      = first_reg;
        res_next        = res_reg;

        in_ready  = 1'b0;
        mod_start = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = probe_reg;
        wr_en     = 1'b0;
        wr_addr   = chk_addr_reg;
        wr_data   = '0;
        res_valid = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Empty one slot a cycle.
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
                if (32'(clr_addr_reg) == 32'(SLOTS - 1))
                    state_next = ST_IDLE;
                else
                    clr_addr_next = clr_addr_reg + AW'(1);
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next = lph_pkg::cmd_t'(in_cmd);
                    key_next = in_key;
                    idx_next = in_idx;
                    if (lph_pkg::cmd_t'(in_cmd) == lph_pkg::CMD_READ)
                        state_next = ST_READ;
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end

            ST_HASH:
            begin
                if (mod_done)
                begin
                    home_next       = home_ext[AW-1:0];
                    probe_next      = home_ext[AW-1:0];
                    issue_left_next = CW'(n);
                    chk_left_next   = CW'(n);
                    first_next      = 1'b1;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue one probe a cycle; its data is checked in the following cycle.
                if (issue_left_reg != '0)
                begin
                    rd_en           = 1'b1;
                    rd_addr         = probe_reg;
                    probe_next      = next_slot(probe_reg, n);
                    issue_left_next = issue_left_reg - CW'(1);
                    chk_addr_next   = probe_reg;
                    chk_valid_next  = 1'b1;
                end

                if (chk_valid_reg)
                begin
                    chk_left_next = chk_left_reg - CW'(1);
                    first_next    = 1'b0;
                    res_next      = '{status:   lph_pkg::STAT_NOT_FOUND,
                                      position: '0, value: '0, occupied: 1'b0};
                    case (cmd_reg)
                        lph_pkg::CMD_INSERT:
                        begin
                            res_next.position = homepos_ext[lph_pkg::POS_W-1:0];
                            if (first_reg)
                            begin
                                // Home always takes the new key.
                                wr_en      = 1'b1;
                                wr_data    = {1'b1, key_reg};
                                moved_next = rd_key;
                                if (!rd_occ)
                                begin
                                    res_next.status = lph_pkg::STAT_INSERTED;
                                    state_next      = ST_DONE;
                                end
                                else if (last_probe)
                                begin
                                    res_next.status = lph_pkg::STAT_DROPPED;
                                    state_next      = ST_DONE;
                                end
                            end
                            else if (!rd_occ)
                            begin
                                wr_en           = 1'b1;
                                wr_data         = {1'b1, moved_reg};
                                res_next.status = lph_pkg::STAT_INSERTED;
                                state_next      = ST_DONE;
                            end
                            else if (last_probe)
                            begin
                                res_next.status = lph_pkg::STAT_DROPPED;
                                state_next      = ST_DONE;
                            end
                        end

                        lph_pkg::CMD_SEARCH, lph_pkg::CMD_DELETE:
                        begin
                            if (rd_occ && (rd_key == key_reg))
                            begin
                                res_next.position = chk_ext[lph_pkg::POS_W-1:0];
                                if (cmd_reg == lph_pkg::CMD_DELETE)
                                begin
                                    wr_en           = 1'b1;
                                    wr_data         = {1'b0, rd_key};
                                    res_next.status = lph_pkg::STAT_DELETED;
                                end
                                else
                                    res_next.status = lph_pkg::STAT_FOUND;
                                state_next = ST_DONE;
                            end
                            else if (last_probe)
                                state_next = ST_DONE;
                        end

                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_ext[AW-1:0];
                state_next = ST_READ_DATA;
            end

            ST_READ_DATA:
            begin
                res_next.status   = lph_pkg::STAT_READ;
                res_next.position = idx_reg;
                if (idx_in_range && rd_occ)
                begin
                    res_next.value    = rd_key;
                    res_next.occupied = 1'b1;
                end
                else
                begin
                    res_next.value    = '0;
                    res_next.occupied = 1'b0;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            cmd_reg        <= lph_pkg::CMD_INSERT;
            key_reg        <= '0;
            idx_reg        <= '0;
            moved_reg      <= '0;
            home_reg       <= '0;
            probe_reg      <= '0;
            chk_addr_reg   <= '0;
            issue_left_reg <= '0;
            chk_left_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            first_reg      <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            cmd_reg        <= cmd_next;
            key_reg        <= key_next;
            idx_reg        <= idx_next;
            moved_reg      <= moved_next;
            home_reg       <= home_next;
            probe_reg      <= probe_next;
            chk_addr_reg   <= chk_addr_next;
            issue_left_reg <= issue_left_next;
            chk_left_reg   <= chk_left_next;
            chk_valid_reg  <= chk_valid_next;
            first_reg      <= first_next;
            res_reg        <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* hdl/linear_probe_hash_table.sv */
// Operation: insert, search and delete reduce the key mod the table size, then probe
//   p slots from the home slot on, p being 1..table size; read slot is one memory read.
// Items: one at a time, bounded by the probe scan; a new item waits until the last result is handed on.
// Reset: asynchronous, active low; a clearing pass then empties every slot,
//   with s_tready low, before the first item is taken.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table of 31-bit keys with linear probing in one
// synchronous slot memory.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table
#(
    parameter int SLOTS = lph_pkg::DEF_SLOTS
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // Input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lph_pkg::S_TDATA_W-1:0]     s_tdata,   // item[30:0], slot_index[37:31]
    input  wire logic [lph_pkg::CMD_W-1:0]         s_tuser,   // command[1:0]

    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [lph_pkg::M_TDATA_W-1:0]          m_tdata,   // position[6:0], value[37:7],
                                                              // occupied[38]
    output logic [lph_pkg::STAT_W-1:0]             m_tuser,   // status[2:0]

    // Configuration: table_size
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lph_pkg::CFG_W-1:0]         cfg_data
);

    localparam int AW = $clog2(SLOTS);

    // Configuration and effective size
    logic [lph_pkg::CFG_W-1:0]     table_size_reg;
    logic [lph_pkg::CFG_W-1:0]     n_eff;

    // Sequencer to output stage
    logic                          res_valid;
    logic                          res_ready;
    lph_pkg::result_t              res;
    lph_pkg::result_t              out_reg;
    logic                          m_tvalid_reg;

    // Remainder unit
    logic                          mod_start;
    logic                          mod_done;
    logic [lph_pkg::CFG_W-1:0]     mod_rem;

    // Slot memory ports
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [lph_pkg::WORD_W-1:0]    rd_data;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [lph_pkg::WORD_W-1:0]    wr_data;

    // Writes must land only while idle, which the block itself does not enforce; take them at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_size_reg <= lph_pkg::DEF_TABLE_SIZE;
        else if (cfg_valid && cfg_ready)
            table_size_reg <= cfg_data;
    end

    // Treat a size of zero as one and clip a size beyond the storage to SLOTS.
    always_comb
    begin
        if (table_size_reg == '0)
            n_eff = lph_pkg::CFG_W'(1);
        else if (32'(table_size_reg) > 32'(SLOTS))
            n_eff = lph_pkg::CFG_W'(SLOTS);
        else
            n_eff = table_size_reg;
    end

    lph_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (s_tdata[lph_pkg::KEY_W-1:0]),
        .divisor   (n_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    lph_ram #(.SLOTS(SLOTS)) u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lph_ctrl #(.SLOTS(SLOTS)) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_key    (s_tdata[lph_pkg::KEY_W-1:0]),
        .in_idx    (s_tdata[lph_pkg::KEY_W +: lph_pkg::IDX_W]),
        .n         (n_eff),
        .mod_start (mod_start),
        .mod_done  (mod_done),
        .mod_rem   (mod_rem),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: hold a result until the master side takes it, and
    // let the sequencer go back to idle as soon as the result has moved here.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            out_reg      <= '0;
        end
        else if (res_valid && res_ready)
        begin
            m_tvalid_reg <= 1'b1;
            out_reg      <= res;
        end
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {1'b0, out_reg.occupied, out_reg.value, out_reg.position};

endmodule

`default_nettype wire

/* hdl/lph_checker.sv */
// ----------------------------------------------------------------------------
// lph_checker
// Port-level checks on the hash table's result stream and reset behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lph_checker
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tready,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [lph_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire logic [lph_pkg::STAT_W-1:0]        m_tuser
);

    // A stalled result holds.
    `LPH_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Only a slot read carries a value or an occupied flag.
    `LPH_ASSERT(a_value_only_read, clk, rst_n, m_tvalid && (m_tuser != lph_pkg::STAT_READ) |-> (m_tdata[38:7] == '0), "value or occupied set outside a slot read")

    // A miss reports position zero.
    `LPH_ASSERT(a_miss_pos, clk, rst_n, m_tvalid && (m_tuser == lph_pkg::STAT_NOT_FOUND) |-> (m_tdata[6:0] == '0), "miss with nonzero position")

    // Nothing is taken or offered while reset is held.
    `LPH_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_tvalid && !s_tready, "stream active in reset")

endmodule

bind linear_probe_hash_table lph_checker u_lph_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

`default_nettype wire
